@@ rtl/core/sipq_pkg.sv @@
// Shared types and constants for the sorted-insert priority queue.
// No dependencies; used by every module of the block.
package sipq_pkg;

    localparam int VALUE_W = 32;
    localparam int OCC_W   = 5;

    // operation codes carried in the request word
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic                      kind;
        logic signed [VALUE_W-1:0] value;
    } req_word_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] removed_value;
        logic [1:0]                status;
        logic [OCC_W-1:0]          occupancy;
    } rsp_word_t;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic                      ins;
        logic                      rem;
        logic signed [VALUE_W-1:0] val;
    } cell_cmd_t;

endpackage

@@ rtl/core/sipq_cell.sv @@
// One storage cell of the sorted chain: holds a value, compares it with
// the broadcast insert value and shifts toward either neighbor. Uses sipq_pkg.
module sipq_cell
(
    input  logic                               clk,
    input  logic                               occupied,
    input  sipq_pkg::cell_cmd_t                cmd,
    input  logic signed [sipq_pkg::VALUE_W-1:0] left_value,
    input  logic                               left_less,
    input  logic signed [sipq_pkg::VALUE_W-1:0] right_value,
    output logic signed [sipq_pkg::VALUE_W-1:0] value,
    output logic                               less
);

    logic signed [sipq_pkg::VALUE_W-1:0] value_reg;
    logic signed [sipq_pkg::VALUE_W-1:0] value_next;

    // stored value sits strictly below the new one, so it stays in front
    assign less  = occupied && (value_reg < cmd.val);
    assign value = value_reg;

    // keep, take the new value, or shift in from a neighbor
    always_comb
    begin
        value_next = value_reg;
        if (cmd.ins)
        begin
            if (less)
                value_next = value_reg;
            else if (left_less)
                value_next = cmd.val;
            else
                value_next = left_value;
        end
        else if (cmd.rem)
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

@@ rtl/core/sipq_out_buf.sv @@
// Output register with a skid stage for the response word.
// Uses sipq_pkg for the response word type.
module sipq_out_buf
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sipq_pkg::rsp_word_t push_word,
    output logic                full,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output sipq_pkg::rsp_word_t rsp
);

    logic                out_valid_reg;
    logic                out_valid_next;
    sipq_pkg::rsp_word_t out_word_reg;
    sipq_pkg::rsp_word_t out_word_next;
    logic                skid_valid_reg;
    logic                skid_valid_next;
    sipq_pkg::rsp_word_t skid_word_reg;
    sipq_pkg::rsp_word_t skid_word_next;

    assign full      = skid_valid_reg;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_word_reg;

    // refill the output register from the skid stage first, else from a new word
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_word_next   = out_word_reg;
        skid_valid_next = skid_valid_reg;
        skid_word_next  = skid_word_reg;
        if (!out_valid_reg || !rsp_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_word_next   = skid_word_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_word_next  = push_word;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_word_next  = push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

endmodule

@@ rtl/core/sorted_insert_priority_queue.sv @@
// Top level of the sorted-insert priority queue: a chain of compare-and-shift
// cells plus a response buffer. Uses sipq_pkg, sipq_cell and sipq_out_buf.
//
// Keeps up to CAPACITY signed 32-bit values in ascending order. Each request
// word is an insert or a remove of the smallest value and gives exactly one
// response word, registered in the response buffer. A word is accepted in
// every cycle while the response buffer has room: every cell compares its
// value with the new one at the same time and shifts by at most one place,
// so an insert or a remove updates the whole store at once, and the two-deep
// response buffer (output register plus skid stage) sets the only stall. An
// insert goes in front of equal values; a remove on an empty store answers
// with the empty status and an insert into a full store with the full
// status, and neither changes the store. Occupancy shows the count modulo 32.
module sorted_insert_priority_queue
#(
    parameter int CAPACITY = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  sipq_pkg::req_word_t req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output sipq_pkg::rsp_word_t rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                accept;
    logic                is_empty;
    logic                is_full;
    logic                buf_full;
    sipq_pkg::cell_cmd_t cmd;
    sipq_pkg::rsp_word_t result;

    logic signed [sipq_pkg::VALUE_W-1:0] value_w [CAPACITY];
    logic                                less_w  [CAPACITY];

    assign req_stall = buf_full;
    assign accept    = req_valid && !buf_full;
    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == CNT_W'(CAPACITY));

    // command to the chain, only for operations that change the store
    always_comb
    begin
        cmd.val = req.value;
        cmd.ins = accept && (req.kind == sipq_pkg::KIND_INSERT) && !is_full;
        cmd.rem = accept && (req.kind == sipq_pkg::KIND_REMOVE) && !is_empty;
    end

    // chain of cells, front of the queue at cell 0
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [sipq_pkg::VALUE_W-1:0] left_value;
        logic                                left_less;
        logic signed [sipq_pkg::VALUE_W-1:0] right_value;

        if (i == 0)
        begin : g_first
            assign left_value = req.value;
            assign left_less  = 1'b0;
        end
        else
        begin : g_inner
            assign left_value = value_w[i-1];
            assign left_less  = less_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_value = value_w[i];
        end
        else
        begin : g_mid
            assign right_value = value_w[i+1];
        end

        sipq_cell u_cell
        (
            .clk         (clk),
            .occupied    (CNT_W'(i) < count_reg),
            .cmd         (cmd),
            .left_value  (left_value),
            .left_less   (left_less),
            .right_value (right_value),
            .value       (value_w[i]),
            .less        (less_w[i])
        );
    end

    // occupancy count
    always_comb
    begin
        count_next = count_reg;
        if (cmd.ins)
            count_next = count_reg + CNT_W'(1);
        else if (cmd.rem)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // response word for the accepted request
    always_comb
    begin
        result.removed_value = '0;
        result.status        = sipq_pkg::STATUS_OK;
        result.occupancy     = sipq_pkg::OCC_W'(count_next);
        if (req.kind == sipq_pkg::KIND_REMOVE)
        begin
            if (is_empty)
                result.status = sipq_pkg::STATUS_EMPTY;
            else
                result.removed_value = value_w[0];
        end
        else if (is_full)
        begin
            result.status = sipq_pkg::STATUS_FULL;
        end
    end

    sipq_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_word (result),
        .full      (buf_full),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("count exceeds capacity");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.kind == sipq_pkg::KIND_INSERT && !is_full)
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the count");

    a_empty_remove_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.kind == sipq_pkg::KIND_REMOVE && is_empty)
        |=> count_reg == '0)
        else $error("remove on empty store changed the count");

    a_front_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CNT_W'(2)) |-> (value_w[0] <= value_w[1]))
        else $error("front of the queue out of order");
`endif

endmodule

@@ tb/tb_sorted_insert_priority_queue.sv @@
// Testbench for the sorted-insert priority queue: directed and random insert/remove words.
// A behavioral copy of the sorted store predicts each response word.
// Depends on sipq_pkg and the sorted_insert_priority_queue RTL.
module tb_sorted_insert_priority_queue;

    localparam int CAPACITY = 16;

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_stall;
    sipq_pkg::req_word_t req;
    logic                rsp_valid;
    logic                rsp_stall;
    sipq_pkg::rsp_word_t rsp;

    // behavioral copy of the store, ascending from index 0
    logic signed [sipq_pkg::VALUE_W-1:0] sorted_copy [CAPACITY];
    int                                  copy_count;

    // response words still owed by the block, oldest first
    sipq_pkg::rsp_word_t due_rsp_q [$];

    int failures;
    int send_gap_pct;
    int stall_pct;

    sorted_insert_priority_queue #(
        .CAPACITY (CAPACITY)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // apply one request word to the copy and return the response it should give
    function automatic sipq_pkg::rsp_word_t next_rsp_word(sipq_pkg::req_word_t w);
        sipq_pkg::rsp_word_t r;
        int                  pos;
        r.removed_value = '0;
        r.status        = sipq_pkg::STATUS_OK;
        if (w.kind == sipq_pkg::KIND_REMOVE)
        begin
            if (copy_count == 0)
            begin
                r.status = sipq_pkg::STATUS_EMPTY;
            end
            else
            begin
                r.removed_value = sorted_copy[0];
                for (int i = 0; i < copy_count - 1; i++)
                    sorted_copy[i] = sorted_copy[i+1];
                copy_count--;
            end
        end
        else if (copy_count >= CAPACITY)
        begin
            r.status = sipq_pkg::STATUS_FULL;
        end
        else
        begin
            // new value goes in front of equal stored values
            pos = 0;
            while (pos < copy_count && sorted_copy[pos] < $signed(w.value))
                pos++;
            for (int i = copy_count; i > pos; i--)
                sorted_copy[i] = sorted_copy[i-1];
            sorted_copy[pos] = w.value;
            copy_count++;
        end
        r.occupancy = sipq_pkg::OCC_W'(copy_count);
        return r;
    endfunction

    // value mix: full range, a narrow band for duplicates, and the extremes
    function automatic logic [sipq_pkg::VALUE_W-1:0] pick_value();
        logic [sipq_pkg::VALUE_W-1:0] v;
        case ($urandom_range(3))
            0: v = $urandom_range(8) - 4;
            1:
            begin
                case ($urandom_range(3))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = 32'h0000_0000;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // send one word, with a random gap before it, and record its response
    task automatic send_word(logic kind, logic [sipq_pkg::VALUE_W-1:0] value);
        sipq_pkg::req_word_t w;
        w.kind  = kind;
        w.value = value;
        while ($urandom_range(99) < send_gap_pct)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req       <= w;
        do
            @(posedge clk);
        while (req_stall);
        due_rsp_q.push_back(next_rsp_word(w));
    endtask

    // hold off the sender until every owed response has come back
    task automatic pause_until_drained();
        @(negedge clk);
        req_valid <= 1'b0;
        while (due_rsp_q.size() != 0)
            @(posedge clk);
    endtask

    // remove on empty, extreme values, duplicates, then empty again
    task automatic test_empty_and_extremes();
        send_word(sipq_pkg::KIND_REMOVE, 32'hFFFF_FFFF);
        send_word(sipq_pkg::KIND_INSERT, 32'h7FFF_FFFF);
        send_word(sipq_pkg::KIND_INSERT, 32'h8000_0000);
        send_word(sipq_pkg::KIND_INSERT, 32'h0000_0000);
        send_word(sipq_pkg::KIND_INSERT, 32'hFFFF_FFFF);
        send_word(sipq_pkg::KIND_INSERT, 32'h0000_0000);
        send_word(sipq_pkg::KIND_INSERT, 32'h0000_0001);
        send_word(sipq_pkg::KIND_INSERT, 32'h8000_0000);
        send_word(sipq_pkg::KIND_INSERT, 32'h7FFF_FFFF);
        repeat (8)
            send_word(sipq_pkg::KIND_REMOVE, $urandom);
        send_word(sipq_pkg::KIND_REMOVE, 32'h0000_0000);
        send_word(sipq_pkg::KIND_REMOVE, 32'h5555_5555);
    endtask

    // fill to capacity, push past it, then drain below empty
    task automatic test_full_store();
        repeat (CAPACITY)
            send_word(sipq_pkg::KIND_INSERT, pick_value());
        repeat (3)
            send_word(sipq_pkg::KIND_INSERT, pick_value());
        repeat (CAPACITY + 2)
            send_word(sipq_pkg::KIND_REMOVE, $urandom);
    endtask

    // random insert/remove mix with a given insert share
    task automatic test_random_mix(int count, int insert_pct);
        repeat (count)
        begin
            if ($urandom_range(99) < insert_pct)
                send_word(sipq_pkg::KIND_INSERT, pick_value());
            else
                send_word(sipq_pkg::KIND_REMOVE, $urandom);
        end
    endtask

    // receiver stall
    always @(negedge clk)
        rsp_stall <= ($urandom_range(99) < stall_pct);

    // response checker
    always @(posedge clk)
    begin : check_rsp
        sipq_pkg::rsp_word_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (due_rsp_q.size() == 0)
            begin
                $display("%0t: unexpected response word removed_value %0d status %0d occupancy %0d",
                         $time, rsp.removed_value, rsp.status, rsp.occupancy);
                failures++;
            end
            else
            begin
                want = due_rsp_q.pop_front();
                if (rsp.removed_value !== want.removed_value)
                begin
                    $display("%0t: removed_value expected %0d actual %0d",
                             $time, want.removed_value, rsp.removed_value);
                    failures++;
                end
                if (rsp.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, rsp.status);
                    failures++;
                end
                if (rsp.occupancy !== want.occupancy)
                begin
                    $display("%0t: occupancy expected %0d actual %0d",
                             $time, want.occupancy, rsp.occupancy);
                    failures++;
                end
            end
        end
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // test sequence
    initial
    begin
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req          = '0;
        rsp_stall    = 1'b0;
        copy_count   = 0;
        failures     = 0;
        send_gap_pct = 0;
        stall_pct    = 0;
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // no idling
        test_empty_and_extremes();
        test_full_store();
        test_random_mix(35, 75);
        test_random_mix(35, 25);
        test_random_mix(30, 50);
        pause_until_drained();

        // sender idles
        send_gap_pct = 48;
        stall_pct    = 0;
        test_random_mix(35, 75);
        test_random_mix(35, 25);
        test_random_mix(30, 50);

        // receiver stalls
        send_gap_pct = 0;
        stall_pct    = 48;
        test_full_store();
        test_random_mix(35, 75);
        test_random_mix(35, 25);
        test_random_mix(30, 50);
        pause_until_drained();

        // both idle
        send_gap_pct = 11;
        stall_pct    = 11;
        test_random_mix(35, 75);
        test_random_mix(35, 25);
        test_random_mix(30, 50);

        pause_until_drained();
        repeat (5)
            @(posedge clk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ sorted_insert_priority_queue.f @@
rtl/core/sipq_pkg.sv
rtl/core/sipq_cell.sv
rtl/core/sipq_out_buf.sv
rtl/core/sorted_insert_priority_queue.sv
tb/tb_sorted_insert_priority_queue.sv
